// File: rtl/uti_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uti_pkg
// Shared widths, latencies, lane codes and helpers for the upper-triangular
// 3x3 inverse core.
// ----------------------------------------------------------------------------
package uti_pkg;

    // field and stream widths
    localparam int WORD_W  = 32;
    localparam int LANES   = 6;
    localparam int DATA_W  = WORD_W * LANES;
    localparam int USER_W  = 2;

    // divider operand widths
    localparam int NUM_W   = 64;          // numerator scale, up to 2^63
    localparam int DEN_W   = 94;          // denominator, up to 2^93
    localparam int REM_W   = DEN_W + 1;   // partial remainder
    localparam int QUO_W   = 32;          // quotient bits below the overflow point

    // pipeline depth
    localparam int FRONT_LAT = 4;
    localparam int DIV_STEPS = QUO_W;
    localparam int DIV_LAT   = DIV_STEPS + 2;
    localparam int PIPE_LAT  = FRONT_LAT + DIV_LAT + 1;

    // lane order, also the field order inside tdata
    localparam int LANE_XX = 0;
    localparam int LANE_XY = 1;
    localparam int LANE_XZ = 2;
    localparam int LANE_YY = 3;
    localparam int LANE_YZ = 4;
    localparam int LANE_ZZ = 5;

    // tuser bit positions on the result side
    localparam int USER_SINGULAR  = 0;
    localparam int USER_SATURATED = 1;

    // saturation limits of the result word
    localparam logic [WORD_W:0]   LIMIT_POS = 33'h0_7FFF_FFFF;
    localparam logic [WORD_W:0]   LIMIT_NEG = 33'h0_8000_0000;
    localparam logic [WORD_W-1:0] SAT_POS   = 32'h7FFF_FFFF;
    localparam logic [WORD_W-1:0] SAT_NEG   = 32'h8000_0000;

    // one divider lane operand set
    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
        logic             neg;
    } div_op_t;

    // one divider lane result
    typedef struct packed {
        logic [WORD_W-1:0] value;
        logic              sat;
    } div_res_t;

    // magnitude of a two's complement word, minimum value maps to 2^31
    function automatic logic [WORD_W-1:0] mag32(input logic [WORD_W-1:0] v);
        return v[WORD_W-1] ? (~v + 32'd1) : v;
    endfunction

endpackage
`default_nettype wire

// File: rtl/uti_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uti_front
// Input register, magnitudes, diagonal products, cofactor and corner
// denominator; builds the six divider operand sets over four stages.
// ----------------------------------------------------------------------------
module uti_front
    import uti_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 en,
    input  wire logic [DATA_W-1:0]    s_data,  // xx, xy, xz, yy, yz, zz from bit 0
    output div_op_t   [LANES-1:0]     ops
);

    // stage 0: captured entries
    logic [WORD_W-1:0] a_reg, b_reg, c_reg, d_reg, e_reg, f_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg <= s_data[LANE_XX*WORD_W +: WORD_W];
            b_reg <= s_data[LANE_XY*WORD_W +: WORD_W];
            c_reg <= s_data[LANE_XZ*WORD_W +: WORD_W];
            d_reg <= s_data[LANE_YY*WORD_W +: WORD_W];
            e_reg <= s_data[LANE_YZ*WORD_W +: WORD_W];
            f_reg <= s_data[LANE_ZZ*WORD_W +: WORD_W];
        end
    end

    // stage 1: magnitudes and the four 32x32 products
    logic [WORD_W-1:0] ma1_reg, md1_reg, mf1_reg, mb1_reg, me1_reg;
    logic [4:0]        sg1_reg;   // na, nd, nf, sb, se
    logic [63:0]       ad1_reg, df1_reg;
    logic signed [63:0] be1_reg, cd1_reg;
    logic [WORD_W-1:0] ma1_next, md1_next, mf1_next;
    logic signed [63:0] be1_next, cd1_next;

    always_comb
    begin
        ma1_next = mag32(a_reg);
        md1_next = mag32(d_reg);
        mf1_next = mag32(f_reg);
        be1_next = 64'($signed(b_reg)) * 64'($signed(e_reg));
        cd1_next = 64'($signed(c_reg)) * 64'($signed(d_reg));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ma1_reg <= ma1_next;
            md1_reg <= md1_next;
            mf1_reg <= mf1_next;
            mb1_reg <= mag32(b_reg);
            me1_reg <= mag32(e_reg);
            sg1_reg <= {e_reg[WORD_W-1], b_reg[WORD_W-1], f_reg[WORD_W-1],
                        d_reg[WORD_W-1], a_reg[WORD_W-1]};
            ad1_reg <= 64'(ma1_next) * 64'(md1_next);
            df1_reg <= 64'(md1_next) * 64'(mf1_next);
            be1_reg <= be1_next;
            cd1_reg <= cd1_next;
        end
    end

    // stage 2: cofactor b*e - c*d as sign and magnitude, corner partial products
    logic [WORD_W-1:0] ma2_reg, md2_reg, mf2_reg, mb2_reg, me2_reg;
    logic [4:0]        sg2_reg;
    logic [63:0]       ad2_reg, df2_reg;
    logic [63:0]       nm2_reg, hip2_reg, lop2_reg;
    logic              nn2_reg;
    logic [64:0]       dif2_next;
    logic [64:0]       ndif2_next;

    always_comb
    begin
        dif2_next  = {be1_reg[63], be1_reg} - {cd1_reg[63], cd1_reg};
        ndif2_next = ~dif2_next + 65'd1;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ma2_reg  <= ma1_reg;
            md2_reg  <= md1_reg;
            mf2_reg  <= mf1_reg;
            mb2_reg  <= mb1_reg;
            me2_reg  <= me1_reg;
            sg2_reg  <= sg1_reg;
            ad2_reg  <= ad1_reg;
            df2_reg  <= df1_reg;
            nn2_reg  <= dif2_next[64];
            nm2_reg  <= dif2_next[64] ? ndif2_next[63:0] : dif2_next[63:0];
            hip2_reg <= 64'(ad1_reg[63:32]) * 64'(mf1_reg);
            lop2_reg <= 64'(ad1_reg[31:0]) * 64'(mf1_reg);
        end
    end

    // stage 3: corner denominator and lane operand sets
    div_op_t [LANES-1:0] ops_reg;
    div_op_t [LANES-1:0] ops_next;
    logic [95:0]         corner_den;
    logic                na, nd, nf, sb, se;

    always_comb
    begin
        {se, sb, nf, nd, na} = sg2_reg;
        corner_den = {hip2_reg, 32'd0} + {32'd0, lop2_reg};

        ops_next[LANE_XX].num = NUM_W'(1);
        ops_next[LANE_XX].den = DEN_W'(ma2_reg);
        ops_next[LANE_XX].neg = na;

        ops_next[LANE_XY].num = NUM_W'(mb2_reg);
        ops_next[LANE_XY].den = DEN_W'(ad2_reg);
        ops_next[LANE_XY].neg = ~(sb ^ na ^ nd);

        ops_next[LANE_XZ].num = nm2_reg;
        ops_next[LANE_XZ].den = corner_den[DEN_W-1:0];
        ops_next[LANE_XZ].neg = nn2_reg ^ na ^ nd ^ nf;

        ops_next[LANE_YY].num = NUM_W'(1);
        ops_next[LANE_YY].den = DEN_W'(md2_reg);
        ops_next[LANE_YY].neg = nd;

        ops_next[LANE_YZ].num = NUM_W'(me2_reg);
        ops_next[LANE_YZ].den = DEN_W'(df2_reg);
        ops_next[LANE_YZ].neg = ~(se ^ nd ^ nf);

        ops_next[LANE_ZZ].num = NUM_W'(1);
        ops_next[LANE_ZZ].den = DEN_W'(mf2_reg);
        ops_next[LANE_ZZ].neg = nf;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ops_reg <= ops_next;
        end
    end

    assign ops = ops_reg;

endmodule
`default_nettype wire

// File: rtl/uti_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uti_div
// Pipelined restoring divider lane: quotient of num * 2^32 / den, one
// quotient bit per stage, then round half away from zero, sign and clip.
// ----------------------------------------------------------------------------
module uti_div
    import uti_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     en,
    input  wire div_op_t  op,
    output div_res_t      res
);

    // per-stage partial remainder, divisor, quotient bits and flags
    logic [REM_W-1:0] rem_reg [0:DIV_STEPS];
    logic [DEN_W-1:0] den_reg [0:DIV_STEPS];
    logic [QUO_W-1:0] quo_reg [0:DIV_STEPS];
    logic             neg_reg [0:DIV_STEPS];
    logic             ovf_reg [0:DIV_STEPS];

    // load: quotient reaches 2^32 exactly when num is not below den
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= REM_W'(op.num);
            den_reg[0] <= op.den;
            quo_reg[0] <= '0;
            neg_reg[0] <= op.neg;
            ovf_reg[0] <= (DEN_W'(op.num) >= op.den);
        end
    end

    // one shift-subtract step per stage
    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_step
        logic [REM_W-1:0] shifted;
        logic             take;

        always_comb
        begin
            shifted = {rem_reg[k][REM_W-2:0], 1'b0};
            take    = (shifted >= {1'b0, den_reg[k]});
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1] <= take ? (shifted - {1'b0, den_reg[k]}) : shifted;
                den_reg[k+1] <= den_reg[k];
                quo_reg[k+1] <= {quo_reg[k][QUO_W-2:0], take};
                neg_reg[k+1] <= neg_reg[k];
                ovf_reg[k+1] <= ovf_reg[k];
            end
        end
    end

    // rounding, sign and saturation
    div_res_t          res_reg;
    div_res_t          res_next;
    logic              rnd;
    logic [WORD_W:0]   quo_rnd;
    logic [WORD_W:0]   limit;
    logic [WORD_W-1:0] neg_val;

    always_comb
    begin
        rnd     = ({rem_reg[DIV_STEPS], 1'b0} >= {2'b00, den_reg[DIV_STEPS]});
        quo_rnd = {1'b0, quo_reg[DIV_STEPS]} + {{WORD_W{1'b0}}, rnd};
        limit   = neg_reg[DIV_STEPS] ? LIMIT_NEG : LIMIT_POS;
        neg_val = ~quo_rnd[WORD_W-1:0] + 32'd1;
        if (ovf_reg[DIV_STEPS] || (quo_rnd > limit))
        begin
            res_next.sat   = 1'b1;
            res_next.value = neg_reg[DIV_STEPS] ? SAT_NEG : SAT_POS;
        end
        else
        begin
            res_next.sat   = 1'b0;
            res_next.value = neg_reg[DIV_STEPS] ? neg_val : quo_rnd[WORD_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule
`default_nettype wire

// File: rtl/upper_triangular_inverse_3x3_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// upper_triangular_inverse_3x3_core
// Inverse of an upper-triangular 3x3 matrix in signed Q16.16, streaming.
// ----------------------------------------------------------------------------
// Accepts one matrix per clock and delivers one inverse per clock. The depth
// is set by the six divider lanes, which resolve one quotient bit per stage
// over 32 stages, behind four front stages (input register, products,
// cofactor, operand sets) and a divider load stage, and ahead of a round
// and an output stage.
// The whole pipeline holds while a result waits on m_tready, so s_tready
// follows the output side. A zero diagonal entry gives all-zero entries with
// the singular flag; any clipped entry sets the saturated flag.
module upper_triangular_inverse_3x3_core
    import uti_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output      logic              s_tready,
    input  wire logic [DATA_W-1:0] s_tdata,   // box_xx, box_xy, box_xz, box_yy, box_yz, box_zz
    output      logic              m_tvalid,
    input  wire logic              m_tready,
    output      logic [DATA_W-1:0] m_tdata,   // inv_xx, inv_xy, inv_xz, inv_yy, inv_yz, inv_zz
    output      logic [USER_W-1:0] m_tuser    // singular, saturated
);

    // pipeline advance: move when the output slot is free or being taken
    logic adv;
    logic [PIPE_LAT-1:0] vld_reg;
    assign adv      = ~vld_reg[PIPE_LAT-1] | m_tready;
    assign s_tready = adv;

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[PIPE_LAT-2:0], s_tvalid};
        end
    end

    // singular flag follows the item down to the output stage
    logic [PIPE_LAT-2:0] sing_reg;
    logic                sing_in;

    always_comb
    begin
        sing_in = (s_tdata[LANE_XX*WORD_W +: WORD_W] == '0) ||
                  (s_tdata[LANE_YY*WORD_W +: WORD_W] == '0) ||
                  (s_tdata[LANE_ZZ*WORD_W +: WORD_W] == '0);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sing_reg <= {sing_reg[PIPE_LAT-3:0], sing_in};
        end
    end

    // operand build
    div_op_t [LANES-1:0] ops;

    uti_front u_front (
        .clk    (clk),
        .en     (adv),
        .s_data (s_tdata),
        .ops    (ops)
    );

    // six divider lanes
    div_res_t [LANES-1:0] res;

    for (genvar i = 0; i < LANES; i++)
    begin : g_lane
        uti_div u_div (
            .clk (clk),
            .en  (adv),
            .op  (ops[i]),
            .res (res[i])
        );
    end

    // output register with singular override
    logic [DATA_W-1:0] data_reg, data_next;
    logic [USER_W-1:0] user_reg, user_next;
    logic              any_sat;

    always_comb
    begin
        any_sat = 1'b0;
        for (int i = 0; i < LANES; i++)
        begin
            data_next[i*WORD_W +: WORD_W] = res[i].value;
            any_sat = any_sat | res[i].sat;
        end
        if (sing_reg[PIPE_LAT-2])
        begin
            data_next = '0;
        end
        user_next[USER_SINGULAR]  = sing_reg[PIPE_LAT-2];
        user_next[USER_SATURATED] = any_sat & ~sing_reg[PIPE_LAT-2];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            data_reg <= data_next;
            user_reg <= user_next;
        end
    end

    assign m_tvalid = vld_reg[PIPE_LAT-1];
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;

endmodule
`default_nettype wire

// File: tb/tb_upper_triangular_inverse_3x3_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_upper_triangular_inverse_3x3_core
// Stream test of the upper-triangular 3x3 inverse core: directed corner
// matrices and random matrices are sent, and each returned inverse is checked
// against an exact rational predictor with round-to-nearest and saturation.
// ----------------------------------------------------------------------------
module tb_upper_triangular_inverse_3x3_core;
    import uti_pkg::*;

    localparam int IDLE_LIMIT = 20000;

    typedef struct {
        logic [WORD_W-1:0] inv [LANES];
        logic              singular;
        logic              saturated;
    } inverse_t;

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata;   // box_xx, box_xy, box_xz, box_yy, box_yz, box_zz
    logic              m_tvalid;
    logic              m_tready;
    logic [DATA_W-1:0] m_tdata;   // inv_xx, inv_xy, inv_xz, inv_yy, inv_yz, inv_zz
    logic [USER_W-1:0] m_tuser;   // singular, saturated

    inverse_t expected_inverses [$];
    int       error_count;
    int       sent_count;
    int       checked_count;
    int       singular_count;
    int       saturated_count;
    int       idle_cycles;
    bit       sender_calm;
    bit       receiver_calm;
    bit       hold_receiver;

    upper_triangular_inverse_3x3_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // rounded quotient with sign, saturated to 32 bits
    function automatic logic [WORD_W-1:0] round_divide(input logic [127:0] num,
                                                       input logic [127:0] den,
                                                       input bit neg,
                                                       inout bit sat);
        logic [127:0] quo;
        logic [127:0] rem;
        logic [127:0] lim;
        quo = num / den;
        rem = num % den;
        if ((rem << 1) >= den)
            quo = quo + 128'd1;
        lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
        if (quo > lim)
        begin
            sat = 1'b1;
            return neg ? SAT_NEG : SAT_POS;
        end
        return neg ? (32'd0 - quo[31:0]) : quo[31:0];
    endfunction

    // predicted inverse of one matrix
    function automatic inverse_t predict_inverse(input logic [DATA_W-1:0] box);
        inverse_t      r;
        logic signed [WORD_W-1:0] ent [LANES];
        logic signed [127:0] a, b, c, d, e, f, cof;
        logic [127:0] ma, md, mf, mcof;
        bit sat;
        for (int i = 0; i < LANES; i++)
            ent[i] = box[i*WORD_W +: WORD_W];
        a = 128'(ent[LANE_XX]); b = 128'(ent[LANE_XY]); c = 128'(ent[LANE_XZ]);
        d = 128'(ent[LANE_YY]); e = 128'(ent[LANE_YZ]); f = 128'(ent[LANE_ZZ]);
        sat = 1'b0;
        r.singular = 1'b0;
        if (a == 0 || d == 0 || f == 0)
        begin
            for (int i = 0; i < LANES; i++)
                r.inv[i] = '0;
            r.singular = 1'b1;
            r.saturated = 1'b0;
            return r;
        end
        ma = (a < 0) ? -a : a;
        md = (d < 0) ? -d : d;
        mf = (f < 0) ? -f : f;
        cof = b * e - c * d;
        mcof = (cof < 0) ? -cof : cof;
        r.inv[LANE_XX] = round_divide(128'd1 << 32, ma, a < 0, sat);
        r.inv[LANE_XY] = round_divide(((b < 0) ? -b : b) << 32, ma * md,
                                      !((b < 0) ^ (a < 0) ^ (d < 0)), sat);
        r.inv[LANE_XZ] = round_divide(mcof << 32, ma * md * mf,
                                      (cof < 0) ^ (a < 0) ^ (d < 0) ^ (f < 0), sat);
        r.inv[LANE_YY] = round_divide(128'd1 << 32, md, d < 0, sat);
        r.inv[LANE_YZ] = round_divide(((e < 0) ? -e : e) << 32, md * mf,
                                      !((e < 0) ^ (d < 0) ^ (f < 0)), sat);
        r.inv[LANE_ZZ] = round_divide(128'd1 << 32, mf, f < 0, sat);
        r.saturated = sat;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                   input logic [WORD_W-1:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        error_count++;
    endtask

    // send one matrix, idling at random before it
    task automatic send_matrix(input logic [DATA_W-1:0] box);
        while (!sender_calm && $urandom_range(99) < 25)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= box;
        expected_inverses.push_back(predict_inverse(box));
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sent_count++;
    endtask

    function automatic logic [WORD_W-1:0] random_word();
        case ($urandom_range(5))
            0: return $urandom_range(1, 4) << $urandom_range(0, 30);
            1: return -($urandom_range(1, 4) << $urandom_range(0, 30));
            2: return $urandom_range(0, 3) ? 32'h0001_0000 : 32'h8000_0000;
            3: return $urandom_range(1, 200000) - 100000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] random_matrix();
        logic [DATA_W-1:0] m;
        for (int i = 0; i < LANES; i++)
            m[i*WORD_W +: WORD_W] = random_word();
        // keep singular matrices to a small share
        for (int i = 0; i < LANES; i += 3)
            if (m[i*WORD_W +: WORD_W] == 0 && $urandom_range(9) != 0)
                m[i*WORD_W +: WORD_W] = $urandom | 32'h1;
        if (m[LANE_YY*WORD_W +: WORD_W] == 0 && $urandom_range(9) != 0)
            m[LANE_YY*WORD_W +: WORD_W] = 32'h0001_0000;
        return m;
    endfunction

    function automatic logic [DATA_W-1:0] pack_box(input logic [WORD_W-1:0] xx,
            input logic [WORD_W-1:0] xy, input logic [WORD_W-1:0] xz,
            input logic [WORD_W-1:0] yy, input logic [WORD_W-1:0] yz,
            input logic [WORD_W-1:0] zz);
        return {zz, yz, yy, xz, xy, xx};
    endfunction

    // receiver ready with random idling and an optional long hold
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= !hold_receiver && (receiver_calm || $urandom_range(99) >= 25);
    end

    // result checker and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_inverses.size() == 0)
                begin
                    $display("result with nothing expected");
                    error_count++;
                end
                else
                begin
                    inverse_t w;
                    w = expected_inverses.pop_front();
                    for (int i = 0; i < LANES; i++)
                        if (m_tdata[i*WORD_W +: WORD_W] !== w.inv[i])
                            report_mismatch($sformatf("lane %0d", i),
                                            m_tdata[i*WORD_W +: WORD_W], w.inv[i]);
                    if (m_tuser[USER_SINGULAR] !== w.singular)
                        report_mismatch("singular", 32'(m_tuser[USER_SINGULAR]),
                                        32'(w.singular));
                    if (m_tuser[USER_SATURATED] !== w.saturated)
                        report_mismatch("saturated", 32'(m_tuser[USER_SATURATED]),
                                        32'(w.saturated));
                    singular_count  += w.singular;
                    saturated_count += w.saturated;
                    checked_count++;
                end
            end
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
                idle_cycles = 0;
            else if (++idle_cycles >= IDLE_LIMIT)
            begin
                $display("watchdog timeout");
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    task automatic test_directed();
        logic [WORD_W-1:0] one, mx, mn;
        one = 32'h0001_0000; mx = 32'h7FFF_FFFF; mn = 32'h8000_0000;
        send_matrix(pack_box(one, 0, 0, one, 0, one));
        send_matrix(pack_box(0, one, one, one, one, one));
        send_matrix(pack_box(one, one, one, 0, one, one));
        send_matrix(pack_box(one, one, one, one, one, 0));
        send_matrix(pack_box(0, 0, 0, 0, 0, 0));
        send_matrix(pack_box(32'd1, mx, mn, 32'd1, mx, 32'd1));
        send_matrix(pack_box(mx, mx, mx, mx, mx, mx));
        send_matrix(pack_box(mn, mn, mn, mn, mn, mn));
        send_matrix(pack_box(mn, mx, mn, mx, mn, mx));
        send_matrix(pack_box(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                             32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_matrix(pack_box(32'h0002_0000, 0, 0, 32'hFFFE_0000, 0, 32'h0004_0000));
        send_matrix(pack_box(32'd3, 32'd1, 32'd1, 32'd3, 32'd1, 32'd3));
        send_matrix(pack_box(one, one, one, one, one, one));
        send_matrix(pack_box(32'd2, one, 0, 32'd2, 0, 32'd2));
        send_matrix(pack_box(32'h0000_8000, 32'h0000_8000, 0, one, 0, one));
        send_matrix(pack_box(32'd131072, 32'hFFFF_0000, one, 32'd131071, 32'd7,
                             32'h0003_0000));
    endtask

    task automatic test_random(input int count);
        for (int i = 0; i < count; i++)
            send_matrix(random_matrix());
    endtask

    // back pressure: hold the receiver while matrices keep coming
    task automatic test_backpressure();
        fork
            begin
                hold_receiver = 1'b1;
                repeat (200) @(posedge clk);
                hold_receiver = 1'b0;
            end
            begin
                sender_calm = 1'b1;
                test_random(80);
                sender_calm = 1'b0;
            end
        join
    endtask

    task automatic test_no_idling();
        sender_calm = 1'b1;
        receiver_calm = 1'b1;
        test_random(150);
        sender_calm = 1'b0;
        receiver_calm = 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        error_count = 0;
        sent_count = 0;
        checked_count = 0;
        singular_count = 0;
        saturated_count = 0;
        idle_cycles = 0;
        sender_calm = 1'b0;
        receiver_calm = 1'b0;
        hold_receiver = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(300);
        test_backpressure();
        test_no_idling();
        test_random(250);
        s_tvalid <= 1'b0;
        while (expected_inverses.size() != 0)
            @(posedge clk);
        repeat (PIPE_LAT + 10) @(posedge clk);
        $display("sent %0d matrices, checked %0d inverses", sent_count, checked_count);
        $display("%0d singular, %0d saturated", singular_count, saturated_count);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
